FILE: hw/rtl/sgah_pkg.sv
package sgah_pkg;

  // Widths of the data path.
  localparam int VALUE_WIDTH = 32;
  localparam int COUNT_WIDTH = 32;
  localparam int KEY_WIDTH   = 32;
  localparam int ACC_WIDTH   = 64;
  localparam int OUT_WIDTH   = 32;
  localparam int DIV_STEPS   = ACC_WIDTH;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  // Depth of the queue between the front and the back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Aggregate function codes.
  localparam logic [2:0] AGG_MIN = 3'd0;
  localparam logic [2:0] AGG_MAX = 3'd1;
  localparam logic [2:0] AGG_SUM = 3'd2;
  localparam logic [2:0] AGG_CNT = 3'd3;
  localparam logic [2:0] AGG_AVG = 3'd4;

  // Comparison codes.
  localparam logic [2:0] CMP_LT = 3'd0;
  localparam logic [2:0] CMP_GT = 3'd1;
  localparam logic [2:0] CMP_GE = 3'd2;
  localparam logic [2:0] CMP_LE = 3'd3;
  localparam logic [2:0] CMP_EQ = 3'd4;
  localparam logic [2:0] CMP_NE = 3'd5;

  // Configuration register indexes.
  localparam logic [1:0] REG_COND_FN   = 2'd0;
  localparam logic [1:0] REG_RET_FN    = 2'd1;
  localparam logic [1:0] REG_CMP_OP    = 2'd2;
  localparam logic [1:0] REG_THRESHOLD = 2'd3;

  localparam logic [OUT_WIDTH-1:0] INT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [ACC_WIDTH:0] VAL_HI =
    {{(ACC_WIDTH-VALUE_WIDTH+2){1'b0}}, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH:0] VAL_LO = ~VAL_HI;

  typedef struct packed {
    logic [2:0]                   cond_fn;
    logic [2:0]                   ret_fn;
    logic [2:0]                   cmp_op;
    logic signed [KEY_WIDTH-1:0]  threshold;
  } cfg_t;

  // A closed group or an end of table, as handed from front to back.
  typedef struct packed {
    logic                         is_end;
    logic                         has_group;
    logic signed [KEY_WIDTH-1:0]  key;
    logic signed [ACC_WIDTH-1:0]  cond_acc;
    logic signed [ACC_WIDTH-1:0]  ret_acc;
    logic [COUNT_WIDTH-1:0]       rows;
  } group_t;

  // Sign extends the used low bits of a row value.
  function automatic logic signed [ACC_WIDTH-1:0] sext_value(input logic [31:0] x);
    logic signed [VALUE_WIDTH-1:0] v;
    v = x[VALUE_WIDTH-1:0];
    return ACC_WIDTH'(v);
  endfunction

  // Folds one value into a running aggregate.
  function automatic logic signed [ACC_WIDTH-1:0] accumulate(
      input logic [2:0] fn, input logic signed [ACC_WIDTH-1:0] acc,
      input logic signed [ACC_WIDTH-1:0] v);
    logic signed [ACC_WIDTH:0] s;
    logic signed [ACC_WIDTH-1:0] r;
    s = {acc[ACC_WIDTH-1], acc} + {v[ACC_WIDTH-1], v};
    r = acc;
    if (fn == AGG_MIN) begin
      r = (v < acc) ? v : acc;
    end else if (fn == AGG_MAX) begin
      r = (v > acc) ? v : acc;
    end else if (fn == AGG_SUM || fn == AGG_AVG) begin
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
        r = s[ACC_WIDTH] ? ACC_MIN : ACC_MAX;
      end else begin
        r = s[ACC_WIDTH-1:0];
      end
    end
    return r;
  endfunction

  function automatic logic compare(input logic [2:0] op,
      input logic signed [ACC_WIDTH-1:0] a, input logic signed [ACC_WIDTH-1:0] b);
    logic r;
    unique case (op)
      CMP_LT:  r = a < b;
      CMP_GT:  r = a > b;
      CMP_GE:  r = a >= b;
      CMP_LE:  r = a <= b;
      CMP_EQ:  r = a == b;
      CMP_NE:  r = a != b;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  // Clamps a result to the signed value range.
  function automatic logic [OUT_WIDTH-1:0] sat_value(input logic signed [ACC_WIDTH:0] r);
    logic signed [ACC_WIDTH:0] c;
    c = r;
    if (r > VAL_HI) c = VAL_HI;
    if (r < VAL_LO) c = VAL_LO;
    return c[OUT_WIDTH-1:0];
  endfunction

endpackage

FILE: hw/rtl/sgah_front.sv
module sgah_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  logic                  command,
  input  logic [31:0]           group_key,
  input  logic [31:0]           cond_value,
  input  logic [31:0]           ret_value,
  input  sgah_pkg::cfg_t        cfg,
  output logic                  q_push,
  output sgah_pkg::group_t      q_data
);

  logic                                   group_open;
  logic signed [sgah_pkg::KEY_WIDTH-1:0]  open_key;
  logic signed [sgah_pkg::ACC_WIDTH-1:0]  cond_acc;
  logic signed [sgah_pkg::ACC_WIDTH-1:0]  ret_acc;
  logic [sgah_pkg::COUNT_WIDTH-1:0]       group_rows;
  logic                                   closing;
  logic signed [sgah_pkg::ACC_WIDTH-1:0]  cv;
  logic signed [sgah_pkg::ACC_WIDTH-1:0]  rv;

  // A data row with a new key closes the open group.
  always_comb begin
    cv      = sgah_pkg::sext_value(cond_value);
    rv      = sgah_pkg::sext_value(ret_value);
    closing = !command && group_open && (group_key != open_key);
    q_push  = accept && (command || closing);
    q_data.is_end    = command;
    q_data.has_group = group_open;
    q_data.key       = open_key;
    q_data.cond_acc  = cond_acc;
    q_data.ret_acc   = ret_acc;
    q_data.rows      = group_rows;
  end

  // Open group state.
  always_ff @(posedge clk) begin
    if (rst) begin
      group_open <= 1'b0;
      group_rows <= '0;
      open_key   <= '0;
      cond_acc   <= '0;
      ret_acc    <= '0;
    end else if (accept) begin
      if (command) begin
        group_open <= 1'b0;
        group_rows <= '0;
      end else if (closing || !group_open) begin
        group_open <= 1'b1;
        open_key   <= group_key;
        cond_acc   <= cv;
        ret_acc    <= rv;
        group_rows <= sgah_pkg::COUNT_WIDTH'(1);
      end else begin
        cond_acc <= sgah_pkg::accumulate(cfg.cond_fn, cond_acc, cv);
        ret_acc  <= sgah_pkg::accumulate(cfg.ret_fn, ret_acc, rv);
        if (group_rows != '1) begin
          group_rows <= group_rows + 1'b1;
        end
      end
    end
  end

endmodule

FILE: hw/rtl/sgah_queue.sv
module sgah_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_en,
  input  sgah_pkg::group_t    push_data,
  input  logic                pop_en,
  output sgah_pkg::group_t    head,
  output logic                q_full,
  output logic                q_empty
);

  sgah_pkg::group_t                 slots [sgah_pkg::QUEUE_DEPTH];
  logic [sgah_pkg::QPTR_W-1:0]      wr_ptr;
  logic [sgah_pkg::QPTR_W-1:0]      rd_ptr;
  logic [sgah_pkg::QCNT_W-1:0]      count;

  assign head    = slots[rd_ptr];
  assign q_full  = count == sgah_pkg::QCNT_W'(sgah_pkg::QUEUE_DEPTH);
  assign q_empty = count == '0;

  // Storage.
  always_ff @(posedge clk) begin
    if (push_en) begin
      slots[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_en) wr_ptr <= wr_ptr + 1'b1;
      if (pop_en)  rd_ptr <= rd_ptr + 1'b1;
      if (push_en && !pop_en) begin
        count <= count + 1'b1;
      end else if (pop_en && !push_en) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/sgah_back.sv
module sgah_back (
  input  logic                    clk,
  input  logic                    rst,
  input  sgah_pkg::cfg_t          cfg,
  input  sgah_pkg::group_t        head,
  input  logic                    q_empty,
  output logic                    q_pop,
  output logic                    out_valid,
  input  logic                    out_taken,
  output logic [31:0]             out_key,
  output logic [31:0]             out_value,
  output logic                    empty_marker
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_OUT  = 5'b10000
  } state_t;

  state_t                                 state;
  sgah_pkg::group_t                       ent;
  logic signed [sgah_pkg::ACC_WIDTH-1:0]  prod;
  logic                                   any_emitted;
  logic [31:0]                            res_key;
  logic [31:0]                            res_val;
  logic                                   res_mark;
  logic [sgah_pkg::ACC_WIDTH-1:0]         num;
  logic [sgah_pkg::COUNT_WIDTH-1:0]       rem;
  logic [sgah_pkg::DIV_CNT_W-1:0]         div_cnt;
  logic                                   div_neg;
  logic [sgah_pkg::COUNT_WIDTH:0]         trial;
  logic                                   fits;
  logic [sgah_pkg::ACC_WIDTH-1:0]         num_next;
  logic [sgah_pkg::COUNT_WIDTH-1:0]       rem_next;
  logic signed [sgah_pkg::ACC_WIDTH:0]    quot_s;
  logic                                   pass;
  logic                                   emit_row;
  logic                                   emit_marker;
  logic signed [sgah_pkg::ACC_WIDTH:0]    ret_raw;
  logic                                   load_out;

  assign q_pop    = (state == ST_IDLE) && !q_empty;
  assign load_out = (state == ST_OUT) && !out_valid;

  // HAVING test and returned aggregate of the group under evaluation.
  always_comb begin
    unique case (cfg.cond_fn)
      sgah_pkg::AGG_MIN, sgah_pkg::AGG_MAX, sgah_pkg::AGG_SUM:
        pass = sgah_pkg::compare(cfg.cmp_op, ent.cond_acc,
                                 sgah_pkg::ACC_WIDTH'(cfg.threshold));
      sgah_pkg::AGG_CNT:
        pass = sgah_pkg::compare(cfg.cmp_op, sgah_pkg::ACC_WIDTH'({1'b0, ent.rows}),
                                 sgah_pkg::ACC_WIDTH'(cfg.threshold));
      sgah_pkg::AGG_AVG:
        pass = sgah_pkg::compare(cfg.cmp_op, ent.cond_acc, prod);
      default:
        pass = sgah_pkg::compare(cfg.cmp_op,
                                 sgah_pkg::ACC_WIDTH'(signed'(sgah_pkg::INT_MIN)),
                                 sgah_pkg::ACC_WIDTH'(cfg.threshold));
    endcase
    emit_row    = ent.has_group && pass;
    emit_marker = ent.is_end && !emit_row && !any_emitted;
    unique case (cfg.ret_fn)
      sgah_pkg::AGG_MIN, sgah_pkg::AGG_MAX, sgah_pkg::AGG_SUM:
        ret_raw = {ent.ret_acc[sgah_pkg::ACC_WIDTH-1], ent.ret_acc};
      sgah_pkg::AGG_CNT:
        ret_raw = (sgah_pkg::ACC_WIDTH+1)'({1'b0, ent.rows});
      default:
        ret_raw = (sgah_pkg::ACC_WIDTH+1)'(signed'(sgah_pkg::INT_MIN));
    endcase
  end

  // One restoring division step on the magnitude of the sum.
  always_comb begin
    trial    = {rem, num[sgah_pkg::ACC_WIDTH-1]};
    fits     = trial >= {1'b0, ent.rows};
    rem_next = fits ? sgah_pkg::COUNT_WIDTH'(trial - {1'b0, ent.rows})
                    : trial[sgah_pkg::COUNT_WIDTH-1:0];
    num_next = {num[sgah_pkg::ACC_WIDTH-2:0], fits};
    quot_s   = div_neg ? -$signed({1'b0, num_next}) : $signed({1'b0, num_next});
  end

  // Control.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      any_emitted <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (out_taken) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (!q_empty) state <= ST_MUL;
        ST_MUL:  state <= ST_CMP;
        ST_CMP: begin
          if (ent.is_end) begin
            any_emitted <= 1'b0;
          end else if (emit_row) begin
            any_emitted <= 1'b1;
          end
          if (emit_row && cfg.ret_fn == sgah_pkg::AGG_AVG) begin
            state <= ST_DIV;
          end else if (emit_row || emit_marker) begin
            state <= ST_OUT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_DIV:  if (div_cnt == '0) state <= ST_OUT;
        ST_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Data path.
  always_ff @(posedge clk) begin
    if (q_pop) ent <= head;
    if (state == ST_MUL) begin
      // The full 64-bit product is needed: threshold times a 32-bit row count.
      prod <= sgah_pkg::ACC_WIDTH'(cfg.threshold) *
              sgah_pkg::ACC_WIDTH'({1'b0, ent.rows});
    end
    if (state == ST_CMP) begin
      res_key  <= emit_row ? ent.key : sgah_pkg::INT_MIN;
      res_val  <= emit_row ? sgah_pkg::sat_value(ret_raw) : sgah_pkg::INT_MIN;
      res_mark <= !emit_row;
      div_neg  <= ent.ret_acc[sgah_pkg::ACC_WIDTH-1];
      num      <= ent.ret_acc[sgah_pkg::ACC_WIDTH-1] ? -ent.ret_acc : ent.ret_acc;
      rem      <= '0;
      div_cnt  <= sgah_pkg::DIV_CNT_W'(sgah_pkg::DIV_STEPS - 1);
    end
    if (state == ST_DIV) begin
      num     <= num_next;
      rem     <= rem_next;
      div_cnt <= div_cnt - 1'b1;
      if (div_cnt == '0) res_val <= sgah_pkg::sat_value(quot_s);
    end
    if (load_out) begin
      out_key      <= res_key;
      out_value    <= res_val;
      empty_marker <= res_mark;
    end
  end

  // The divider never runs against an empty group.
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> ent.rows != '0)
    else $error("division by zero row count");

  // A queue entry is taken only between groups.
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> state == ST_MUL)
    else $error("queue entry taken while busy");

  // The output register is never overwritten while it holds a word.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_taken) |=> out_valid && $stable(out_key) && $stable(out_value))
    else $error("pending result overwritten");

endmodule

FILE: hw/rtl/sorted_group_aggregate_having.sv
// Sorted group-by aggregation with a HAVING filter.
// Throughput: one row per cycle at the input while the group queue has room.
// Path: a closed group goes through the queue to the back end: multiply,
// compare, the 64-step divider if the average is returned, then output.
// Reset: synchronous rst clears the open group, the queue and the output;
// the configuration registers return to zero.
module sorted_group_aggregate_having (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  output logic         full,
  input  logic         command,
  input  logic [31:0]  group_key,
  input  logic [31:0]  cond_value,
  input  logic [31:0]  ret_value,
  output logic         empty,
  input  logic         pop,
  output logic [31:0]  out_key,
  output logic [31:0]  out_value,
  output logic         empty_marker,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [31:0]  cfg_data
);

  sgah_pkg::cfg_t    cfg;
  sgah_pkg::group_t  q_data;
  sgah_pkg::group_t  head;
  logic              q_push;
  logic              q_pop;
  logic              q_empty;
  logic              out_valid;

  assign cfg_ready = 1'b1;
  assign empty     = !out_valid;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        sgah_pkg::REG_COND_FN:   cfg.cond_fn   <= cfg_data[2:0];
        sgah_pkg::REG_RET_FN:    cfg.ret_fn    <= cfg_data[2:0];
        sgah_pkg::REG_CMP_OP:    cfg.cmp_op    <= cfg_data[2:0];
        sgah_pkg::REG_THRESHOLD: cfg.threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  sgah_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (push && !full),
    .command    (command),
    .group_key  (group_key),
    .cond_value (cond_value),
    .ret_value  (ret_value),
    .cfg        (cfg),
    .q_push     (q_push),
    .q_data     (q_data)
  );

  sgah_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_en   (q_push),
    .push_data (q_data),
    .pop_en    (q_pop),
    .head      (head),
    .q_full    (full),
    .q_empty   (q_empty)
  );

  sgah_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .head         (head),
    .q_empty      (q_empty),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_taken    (pop && out_valid),
    .out_key      (out_key),
    .out_value    (out_value),
    .empty_marker (empty_marker)
  );

endmodule
